// File: rtl/ac3fs_pkg.sv
// ac3fs_pkg: shared types, constants and lookup functions for the ac3 frame sync checker
// holds the crc-16 byte update and the bit rate / frame length tables; no dependencies
`timescale 1ns / 1ps

package ac3fs_pkg;

    localparam logic [15:0] SYNC_WORD    = 16'h0B77;
    localparam logic [15:0] CRC_POLY     = 16'h8005;
    localparam logic [15:0] SYNC_IDLE    = 16'hFFFF;
    localparam logic [11:0] POS_START    = 12'd2;
    localparam logic [11:0] POS_RATE_HDR = 12'd4;
    localparam logic [11:0] POS_ID_HDR   = 12'd5;
    localparam logic [11:0] POS_HDR_DONE = 12'd6;
    localparam logic [5:0]  SIZE_LIMIT   = 6'd38;

    // fscod values
    localparam logic [1:0] FS_48K  = 2'd0;
    localparam logic [1:0] FS_44K1 = 2'd1;
    localparam logic [1:0] FS_32K  = 2'd2;
    localparam logic [1:0] FS_RSVD = 2'd3;

    // status codes of a result
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_CRC_FAIL = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  rate_code;
        logic [4:0]  stream_id;
        logic [2:0]  stream_mode;
        logic [9:0]  bit_rate_kbps;
        logic [10:0] frame_words;
    } result_t;

    // msb-first crc-16 over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // nominal bit rate, index clamps at the top entry
    function automatic logic [9:0] rate_lut(input logic [4:0] idx);
        logic [9:0] r;
        case (idx)
            5'd0:    r = 10'd32;
            5'd1:    r = 10'd40;
            5'd2:    r = 10'd48;
            5'd3:    r = 10'd56;
            5'd4:    r = 10'd64;
            5'd5:    r = 10'd80;
            5'd6:    r = 10'd96;
            5'd7:    r = 10'd112;
            5'd8:    r = 10'd128;
            5'd9:    r = 10'd160;
            5'd10:   r = 10'd192;
            5'd11:   r = 10'd224;
            5'd12:   r = 10'd256;
            5'd13:   r = 10'd320;
            5'd14:   r = 10'd384;
            5'd15:   r = 10'd448;
            5'd16:   r = 10'd512;
            5'd17:   r = 10'd576;
            default: r = 10'd640;
        endcase
        return r;
    endfunction

    // frame words at 44.1 kHz for the even size code
    function automatic logic [10:0] words441_lut(input logic [4:0] idx);
        logic [10:0] w;
        case (idx)
            5'd0:    w = 11'd69;
            5'd1:    w = 11'd87;
            5'd2:    w = 11'd104;
            5'd3:    w = 11'd121;
            5'd4:    w = 11'd139;
            5'd5:    w = 11'd174;
            5'd6:    w = 11'd208;
            5'd7:    w = 11'd243;
            5'd8:    w = 11'd278;
            5'd9:    w = 11'd348;
            5'd10:   w = 11'd417;
            5'd11:   w = 11'd487;
            5'd12:   w = 11'd557;
            5'd13:   w = 11'd696;
            5'd14:   w = 11'd835;
            5'd15:   w = 11'd975;
            5'd16:   w = 11'd1114;
            5'd17:   w = 11'd1253;
            default: w = 11'd1393;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ac3_frame_sync_crc_check_unit.sv
// ac3 frame sync and crc check: the result of the last byte of a frame (or of the second
// header byte on rejection) goes to the output or skid register; throughput one byte per
// cycle while in_ready is high, set by the byte-wide crc and position counter update.
// an output register plus a skid register let bytes flow while a result waits.
// rst_n clears the control state asynchronously: the block hunts for sync, rate code 0.
// depends on ac3fs_pkg
`timescale 1ns / 1ps

module ac3_frame_sync_crc_check_unit
    import ac3fs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [1:0]  rate_code,
    output logic [4:0]  stream_id,
    output logic [2:0]  stream_mode,
    output logic [9:0]  bit_rate_kbps,
    output logic [10:0] frame_words
);

    logic [1:0]  exp_rate_reg;
    logic [15:0] sync_reg,     sync_next;
    logic [11:0] pos_reg,      pos_next;
    logic [11:0] fbytes_reg,   fbytes_next;
    logic [15:0] crc_reg,      crc_next;
    logic [1:0]  hdr_rate_reg, hdr_rate_next;
    logic [5:0]  hdr_size_reg, hdr_size_next;
    logic [4:0]  hdr_id_reg,   hdr_id_next;
    logic [2:0]  hdr_mode_reg, hdr_mode_next;

    logic        out_valid_reg,  skid_valid_reg;
    result_t     out_data_reg,   skid_data_reg;

    logic        accept;
    logic        emit;
    result_t     res;
    logic [15:0] crc_upd;
    logic [11:0] pos_inc;
    logic [9:0]  tbl_rate;
    logic [10:0] tbl_words;
    logic        out_take;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    always_comb
    begin
        sync_next     = sync_reg;
        pos_next      = pos_reg;
        fbytes_next   = fbytes_reg;
        crc_next      = crc_reg;
        hdr_rate_next = hdr_rate_reg;
        hdr_size_next = hdr_size_reg;
        hdr_id_next   = hdr_id_reg;
        hdr_mode_next = hdr_mode_reg;
        emit          = 1'b0;
        res.status    = STATUS_OK;
        crc_upd       = crc16_byte(crc_reg, data_byte);
        pos_inc       = pos_reg + 12'd1;

        if (pos_reg == POS_RATE_HDR)
        begin
            hdr_rate_next = data_byte[7:6];
            hdr_size_next = data_byte[5:0];
        end
        if (pos_reg == POS_ID_HDR)
        begin
            hdr_id_next   = data_byte[7:3];
            hdr_mode_next = data_byte[2:0];
        end

        tbl_rate = rate_lut(hdr_size_next[5:1]);
        case (hdr_rate_next)
            FS_48K:  tbl_words = {tbl_rate, 1'b0};
            FS_44K1: tbl_words = words441_lut(hdr_size_next[5:1]) + {10'd0, hdr_size_next[0]};
            default: tbl_words = {1'b0, tbl_rate} + {tbl_rate, 1'b0};
        endcase

        res.bit_rate_kbps = tbl_rate;
        res.frame_words   = tbl_words;

        if (accept)
        begin
            if (sync_reg != SYNC_WORD)
            begin
                // still hunting, header capture must not act
                hdr_rate_next = hdr_rate_reg;
                hdr_size_next = hdr_size_reg;
                hdr_id_next   = hdr_id_reg;
                hdr_mode_next = hdr_mode_reg;
                sync_next     = {sync_reg[7:0], data_byte};
                if ({sync_reg[7:0], data_byte} == SYNC_WORD)
                    crc_next = 16'd0;
            end
            else
            begin
                crc_next = crc_upd;
                pos_next = pos_inc;
                if (fbytes_reg == 12'd0)
                begin
                    if (pos_inc >= POS_HDR_DONE)
                    begin
                        if (hdr_rate_next == FS_RSVD || hdr_size_next >= SIZE_LIMIT)
                        begin
                            emit              = 1'b1;
                            res.status        = STATUS_BAD_HDR;
                            res.bit_rate_kbps = 10'd0;
                            res.frame_words   = 11'd0;
                        end
                        else if (hdr_rate_next != exp_rate_reg)
                        begin
                            emit       = 1'b1;
                            res.status = STATUS_MISMATCH;
                        end
                        else
                            fbytes_next = {tbl_words, 1'b0};
                    end
                end
                else if (pos_inc >= fbytes_reg)
                begin
                    emit            = 1'b1;
                    res.status      = (crc_upd == 16'd0) ? STATUS_OK : STATUS_CRC_FAIL;
                    res.frame_words = fbytes_reg[11:1];
                end
            end
        end
        else
        begin
            hdr_rate_next = hdr_rate_reg;
            hdr_size_next = hdr_size_reg;
            hdr_id_next   = hdr_id_reg;
            hdr_mode_next = hdr_mode_reg;
        end

        res.rate_code   = hdr_rate_next;
        res.stream_id   = hdr_id_next;
        res.stream_mode = hdr_mode_next;

        // back to hunting after every result
        if (emit)
        begin
            sync_next   = SYNC_IDLE;
            pos_next    = POS_START;
            fbytes_next = 12'd0;
            crc_next    = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_rate_reg <= FS_48K;
            sync_reg     <= SYNC_IDLE;
            pos_reg      <= POS_START;
            fbytes_reg   <= 12'd0;
            crc_reg      <= 16'd0;
            hdr_rate_reg <= 2'd0;
            hdr_size_reg <= 6'd0;
            hdr_id_reg   <= 5'd0;
            hdr_mode_reg <= 3'd0;
        end
        else
        begin
            if (cfg_we)
                exp_rate_reg <= cfg_wdata;
            sync_reg     <= sync_next;
            pos_reg      <= pos_next;
            fbytes_reg   <= fbytes_next;
            crc_reg      <= crc_next;
            hdr_rate_reg <= hdr_rate_next;
            hdr_size_reg <= hdr_size_next;
            hdr_id_reg   <= hdr_id_next;
            hdr_mode_reg <= hdr_mode_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
            out_valid_reg <= emit;
        else if (emit)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (emit)
                out_data_reg <= res;
        end
        else if (emit)
            skid_data_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_data_reg.status;
    assign rate_code     = out_data_reg.rate_code;
    assign stream_id     = out_data_reg.stream_id;
    assign stream_mode   = out_data_reg.stream_mode;
    assign bit_rate_kbps = out_data_reg.bit_rate_kbps;
    assign frame_words   = out_data_reg.frame_words;

endmodule
